// File: src/hti_pkg.sv
// shared widths, register indexes and types of the height map interpolation unit
package hti_pkg;

  localparam int ADDR_W   = 16;
  localparam int HEIGHT_W = 8;
  localparam int COORD_W  = 18;
  localparam int OUT_W    = 16;
  localparam int FRAC_W   = 8;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_LIMIT  = 1'd1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [HEIGHT_W-1:0] height_t;

  typedef struct packed {
    height_t            a;
    height_t            b;
    height_t            c;
    height_t            d;
    logic [FRAC_W-1:0]  dx;
    logic [FRAC_W-1:0]  dz;
  } blend_in_t;

endpackage

// File: src/hti_in_if.sv
// input channel: write or query item with valid/ready handshake
interface hti_in_if;
  import hti_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [ADDR_W-1:0]          write_addr;
  logic [HEIGHT_W-1:0]        write_height;
  logic signed [COORD_W-1:0]  query_x;
  logic signed [COORD_W-1:0]  query_z;

  modport source (output valid, cmd, write_addr, write_height, query_x, query_z,
                  input ready);
  modport sink (input valid, cmd, write_addr, write_height, query_x, query_z,
                output ready);
endinterface

// File: src/hti_out_if.sv
// output channel: interpolated height with valid/ready handshake
interface hti_out_if;
  import hti_pkg::*;

  logic               valid;
  logic               ready;
  logic [OUT_W-1:0]   height_out;

  modport source (output valid, height_out, input ready);
  modport sink (input valid, height_out, output ready);
endinterface

// File: src/heightmap_triangle_interp_unit.sv
// top level of the height map triangle interpolation unit
// query: clamp, row multiply, two corner reads, then the blend; next item taken once the result is loaded
// write: next item taken once the store is done (address reduction, then store)
// corner reads share the two read ports of the height memory: row r0 in S_Q_RDAB, row r1 in S_Q_RDCD
// reset clears control and configuration registers only; the height memory is undefined until written
module heightmap_triangle_interp_unit #(
  parameter int GRID_MAX = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [hti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hti_pkg::CFG_W-1:0]      cfg_data,
  hti_in_if.sink                         in_ch,
  hti_out_if.source                      out_ch
);
  import hti_pkg::*;

  localparam int DEPTH   = GRID_MAX * GRID_MAX;
  localparam int AW      = $clog2(DEPTH);
  localparam int IDX_W   = $clog2(GRID_MAX);
  localparam int LIM_W   = $clog2(GRID_MAX + 1);
  localparam int DEPTH_W = $clog2(DEPTH + 1);
  localparam int QD_W    = ADDR_W + DEPTH_W;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_V = DEPTH_W'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_W1, S_W2, S_W3, S_Q_CLAMP, S_Q_MUL, S_Q_RDAB, S_Q_RDCD,
    S_Q_WAIT, S_BLEND, S_OUT
  } state_t;

  state_t state;

  logic [CFG_W-1:0]    row_stride;
  logic [CFG_W-1:0]    col_limit;

  logic [ADDR_W-1:0]   wr_addr;
  height_t             wr_height;
  logic [ADDR_W-1:0]   wq;
  logic [QD_W-1:0]     wqd;
  logic [COORD_W-1:0]  ux, uz;

  logic [IDX_W-1:0]    r0, r1, c0, c1;
  logic [LIM_W-1:0]    stride_q;
  logic [AW-1:0]       rs0, rs1;
  height_t             a_q, b_q;

  logic                out_valid;
  logic [OUT_W-1:0]    out_height;

  logic                in_fire;
  logic [LIM_W-1:0]    stride_eff, col_eff;
  logic signed [10:0]  col, col1, row, row1;
  logic [47:0]         prod1;
  logic [16:0]         rem;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, raddr0, raddr1;
  height_t             rdata0, rdata1;
  logic                blend_start, blend_done, out_free, out_load;
  blend_in_t           blend_in;
  logic [OUT_W-1:0]    blend_result;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [10:0] idx,
                                                 input logic [LIM_W-1:0] lim);
    logic signed [11:0] hi;
    logic [IDX_W-1:0]   res;
    begin
      hi = (lim == '0) ? 12'sd0 : $signed(12'(lim)) - 12'sd1;
      if (idx < 11'sd0) begin
        res = '0;
      end else if (idx > hi) begin
        res = IDX_W'(hi);
      end else begin
        res = IDX_W'(idx);
      end
      return res;
    end
  endfunction

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.height_out = out_height;
  assign out_free     = !out_valid || out_ch.ready;
  assign out_load     = out_free && ((state == S_BLEND && blend_done) || state == S_OUT);

  always_comb begin
    stride_eff = (int'(row_stride) > GRID_MAX) ? LIM_W'(GRID_MAX) : LIM_W'(row_stride);
    col_eff    = (int'(col_limit) > GRID_MAX) ? LIM_W'(GRID_MAX) : LIM_W'(col_limit);
    col  = $signed({1'b0, ux[17:8]}) - 11'sd512;
    row  = $signed({1'b0, uz[17:8]}) - 11'sd512;
    col1 = col + 11'sd1;
    row1 = row + 11'sd1;

    prod1 = 48'(wr_addr) * 48'(RECIP);
    rem   = 17'(wr_addr) - 17'(wqd);
    if (int'(rem) >= DEPTH) begin
      mem_waddr = AW'(rem - 17'(DEPTH));
    end else begin
      mem_waddr = AW'(rem);
    end
    mem_we = (state == S_W3);

    if (state == S_Q_RDCD) begin
      raddr0 = rs1 + AW'(c0);
      raddr1 = rs1 + AW'(c1);
    end else begin
      raddr0 = rs0 + AW'(c0);
      raddr1 = rs0 + AW'(c1);
    end

    blend_start = (state == S_Q_WAIT);
    blend_in.a  = a_q;
    blend_in.b  = b_q;
    blend_in.c  = rdata0;
    blend_in.d  = rdata1;
    blend_in.dx = ux[FRAC_W-1:0];
    blend_in.dz = uz[FRAC_W-1:0];
  end

  hti_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (wr_height),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  hti_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .start    (blend_start),
    .blend_in (blend_in),
    .done     (blend_done),
    .result   (blend_result)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride <= CFG_W'(256);
      col_limit  <= CFG_W'(256);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_STRIDE: row_stride <= cfg_data;
        REG_COL_LIMIT:  col_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= (in_ch.cmd == CMD_QUERY) ? S_Q_CLAMP : S_W1;
          end
        end
        S_W1:      state <= S_W2;
        S_W2:      state <= S_W3;
        S_W3:      state <= S_IDLE;
        S_Q_CLAMP: state <= S_Q_MUL;
        S_Q_MUL:   state <= S_Q_RDAB;
        S_Q_RDAB:  state <= S_Q_RDCD;
        S_Q_RDCD:  state <= S_Q_WAIT;
        S_Q_WAIT:  state <= S_BLEND;
        S_BLEND: begin
          if (blend_done) begin
            if (out_free) begin
              out_valid  <= 1'b1;
              out_height <= blend_result;
              state      <= S_IDLE;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_height <= blend_result;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      wr_addr   <= in_ch.write_addr;
      wr_height <= in_ch.write_height;
      ux        <= in_ch.query_x ^ 18'h20000;
      uz        <= in_ch.query_z ^ 18'h20000;
    end
    if (state == S_W1) begin
      wq <= prod1[47:32];
    end
    if (state == S_W2) begin
      wqd <= QD_W'(wq) * QD_W'(DEPTH_V);
    end
    if (state == S_Q_CLAMP) begin
      r0       <= clamp_idx(row, stride_eff);
      r1       <= clamp_idx(row1, stride_eff);
      c0       <= clamp_idx(col, col_eff);
      c1       <= clamp_idx(col1, col_eff);
      stride_q <= stride_eff;
    end
    if (state == S_Q_MUL) begin
      rs0 <= AW'(r0 * stride_q);
      rs1 <= AW'(r1 * stride_q);
    end
    if (state == S_Q_RDCD) begin
      a_q <= rdata0;
      b_q <= rdata1;
    end
  end

`ifndef SYNTHESIS
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.cmd == CMD_QUERY) |=> (state == S_Q_CLAMP))
    else $error("query transfer did not start the corner path");

  a_write_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.cmd == CMD_WRITE) |=> ##2 mem_we)
    else $error("write transfer did not reach the height memory");

  a_blend_in_state: assert property (@(posedge clk) disable iff (rst)
    blend_done |-> (state == S_BLEND))
    else $error("blend finished outside its wait state");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_BLEND || $past(state) == S_OUT))
    else $error("result shown without a finished blend");
`endif

endmodule

// File: src/hti_store.sv
// height memory: one write port, two registered read ports
module hti_store #(
  parameter int DEPTH = 65536,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  hti_pkg::height_t         wdata,
  input  logic [AW-1:0]            raddr0,
  input  logic [AW-1:0]            raddr1,
  output hti_pkg::height_t         rdata0,
  output hti_pkg::height_t         rdata1
);
  import hti_pkg::*;

  height_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: src/hti_blend.sv
// two-stage triangle blend of four corner heights
module hti_blend (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  hti_pkg::blend_in_t       blend_in,
  output logic                     done,
  output logic [hti_pkg::OUT_W-1:0] result
);
  import hti_pkg::*;

  logic               low_tri;
  logic [8:0]         f1, f2;
  logic signed [8:0]  e1, e2;
  height_t            base;
  logic signed [18:0] p1, p2;
  logic signed [19:0] sum;

  height_t            base_q;
  logic signed [18:0] p1_q, p2_q;
  logic               v1;

  always_comb begin
    low_tri = ~(9'({1'b0, blend_in.dx} + {1'b0, blend_in.dz}) >= 9'd256);
    if (low_tri) begin
      base = blend_in.a;
      f1   = {1'b0, blend_in.dx};
      f2   = {1'b0, blend_in.dz};
      e1   = $signed({1'b0, blend_in.b}) - $signed({1'b0, blend_in.a});
      e2   = $signed({1'b0, blend_in.c}) - $signed({1'b0, blend_in.a});
    end else begin
      base = blend_in.d;
      f1   = 9'd256 - {1'b0, blend_in.dx};
      f2   = 9'd256 - {1'b0, blend_in.dz};
      e1   = $signed({1'b0, blend_in.c}) - $signed({1'b0, blend_in.d});
      e2   = $signed({1'b0, blend_in.b}) - $signed({1'b0, blend_in.d});
    end
    p1  = 19'($signed({1'b0, f1}) * e1);
    p2  = 19'($signed({1'b0, f2}) * e2);
    sum = $signed({4'b0, base_q, 8'b0}) + 20'(p1_q) + 20'(p2_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base_q <= base;
      p1_q   <= p1;
      p2_q   <= p2;
    end
    if (v1) begin
      result <= sum[OUT_W-1:0];
    end
  end

endmodule
